// ----- hdl/lgs_pkg.sv -----
// shared types, constants and the life rule for the life generation stencil
`default_nettype none

package lgs_pkg;

    // fixed field widths
    localparam int CELL_W     = 8;
    localparam int DIM_W      = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 9;

    // byte of a live cell, in and out
    localparam logic [CELL_W-1:0] ALIVE_BYTE = 8'hFF;

    // command carried on tuser
    localparam logic CMD_CELL = 1'b0;

    // register reset values
    localparam logic [DIM_W-1:0]  FRAME_WIDTH_RESET  = 9'd200;
    localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RESET = 9'd200;
    localparam logic [CELL_W-1:0] DEAD_MARK_RESET    = 8'd0;

    // configuration register indices
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_DEAD_MARK    = 2'd2
    } reg_index_t;

    // control sequence of the top level
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_START,
        ST_DIVIDE,
        ST_LOAD,
        ST_RUN
    } state_t;

    // b3/s23 on a 3x3 window, centre is bit 4
    function automatic logic life_rule(input logic [8:0] win);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
            begin
                n = n + 4'(win[i]);
            end
        end
        if (win[4])
        begin
            return (n == 4'd2) || (n == 4'd3);
        end
        return n == 4'd3;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/lgs_window_cell.sv -----
// one column cell of the 3x3 window chain
`default_nettype none

module lgs_window_cell
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift,
    input  wire logic       flush,
    input  wire logic [2:0] d,
    output logic      [2:0] q,
    output logic      [2:0] q_next
);

    logic [2:0] col_reg;

    // flush empties the cell at the start of a row
    always_comb
    begin
        q_next = col_reg;
        if (shift)
        begin
            q_next = flush ? 3'b000 : d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= 3'b000;
        end
        else
        begin
            col_reg <= q_next;
        end
    end

    assign q = col_reg;

endmodule

`default_nettype wire

// ----- hdl/lgs_line_buffer.sv -----
// two-line buffer memory, one entry per column, with clearing pass after reset
`default_nettype none

module lgs_line_buffer
#(
    parameter int DEPTH = 256
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [1:0]               wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [1:0]               rd_data,
    output logic                          clearing
);

    localparam int A_W = $clog2(DEPTH);

    // bit 0 middle line, bit 1 upper line
    logic [1:0]     mem [DEPTH];
    logic [1:0]     rd_data_reg;
    logic [A_W-1:0] clr_cnt_reg;
    logic [A_W-1:0] clr_cnt_next;
    logic           clr_done_reg;
    logic           clr_done_next;
    logic           mem_we;
    logic [A_W-1:0] mem_waddr;
    logic [1:0]     mem_wdata;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_done_next = clr_done_reg;
        if (!clr_done_reg)
        begin
            clr_cnt_next = clr_cnt_reg + A_W'(1);
            if (clr_cnt_reg == A_W'(DEPTH - 1))
            begin
                clr_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_done_reg <= clr_done_next;
        end
    end

    assign mem_we    = !clr_done_reg || wr_en;
    assign mem_waddr = clr_done_reg ? wr_addr : clr_cnt_reg;
    assign mem_wdata = clr_done_reg ? wr_data : 2'b00;

    // write-through when the next column is the one being written
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = !clr_done_reg;

endmodule

`default_nettype wire

// ----- hdl/lgs_pos_divider.sv -----
// restoring divider, one quotient bit per cycle, splits position into row and column
`default_nettype none

module lgs_pos_divider
#(
    parameter int NUM_W = 17,
    parameter int DEN_W = 9
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quo,
    output logic      [DEN_W-1:0] rem,
    output logic                  done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(NUM_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- hdl/life_generation_stencil.sv -----
// top level: one b3/s23 life generation over a raster-order cell stream
//
// cells arrive one per transaction in raster order and the block takes one transaction
// per clock while s_tready is high, set by the single read-modify-write of the line
// buffer memory per column; a cell is alive when its byte is 255 and tuser is low, and
// cells outside the frame count as dead. the result for a cell comes out frame_width+1
// transactions after the cell went in, so a frame of width*height cells is followed by
// width+1 flush transactions (tuser high) to push out its tail; the last result of a
// frame carries tlast and the next transaction starts a new frame. a dead cell is sent
// as the dead_mark byte. a two-entry output queue lets input continue while one result
// waits. after reset the line buffer is swept to dead, and s_tready stays low through
// the sweep and the load state after it. each configuration write after the sweep holds
// s_tready low while the current position is split again into row and column by a
// bit-serial divider; write configuration only with no results outstanding.
`default_nettype none

module life_generation_stencil
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lgs_pkg::CELL_W-1:0]       s_tdata,   // [7:0] cell_value
    input  wire logic                             s_tuser,   // [0] command
    // output stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [lgs_pkg::CELL_W-1:0]       m_tdata,   // [7:0] next_value
    output logic                                  m_tlast,   // frame_end
    // configuration writes
    input  wire logic                             cfg_we,
    input  wire logic [lgs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [lgs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int C_W  = $clog2(MAX_WIDTH);                           // column index
    localparam int WC_W = $clog2(MAX_WIDTH + 1);                       // clamped width
    localparam int HC_W = $clog2(MAX_HEIGHT + 1);                      // clamped height
    localparam int P_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1); // input position
    localparam int O_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);              // output position
    localparam int WH_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);          // cells per frame
    localparam int PR_W = WC_W + HC_W;

    localparam int DIM_W  = lgs_pkg::DIM_W;
    localparam int CELL_W = lgs_pkg::CELL_W;

    // configuration registers
    logic [DIM_W-1:0]  fw_reg;
    logic [DIM_W-1:0]  fh_reg;
    logic [CELL_W-1:0] dm_reg;

    // clamped frame size and cells per frame
    logic [WC_W-1:0]   wc;
    logic [HC_W-1:0]   hc;
    logic [PR_W-1:0]   wh_prod;
    logic [WH_W-1:0]   wh_reg;

    // control sequence
    lgs_pkg::state_t   state_reg;
    lgs_pkg::state_t   state_next;

    // stream position: raw position, row and column in the frame, results given
    logic [P_W-1:0]    p_reg;
    logic [P_W-1:0]    p_next;
    logic [P_W-1:0]    r_reg;
    logic [P_W-1:0]    r_next;
    logic [C_W-1:0]    c_reg;
    logic [C_W-1:0]    c_next;
    logic [O_W-1:0]    out_pos_reg;
    logic [O_W-1:0]    out_pos_next;

    // next state of the last cell of a row, held until it comes round
    logic              edge_reg;
    logic              edge_next;

    // per-transaction datapath
    logic              accept;
    logic              cell_bot;
    logic              cell_mid;
    logic              cell_top;
    logic [2:0]        col;
    logic              col_first;
    logic              col_last;
    logic              has_result;
    logic              frame_last;
    logic              alive;
    logic [CELL_W-1:0] res_data;
    logic [8:0]        win_next;

    // line buffer
    logic [1:0]        lb_rd_data;
    logic              lb_clearing;
    logic              lb_rd_en;

    // position divider
    logic              div_start;
    logic [P_W-1:0]    div_quo;
    logic [WC_W-1:0]   div_rem;
    logic              div_done;

    // window chain
    logic [2:0]        cell0_q;
    logic [2:0]        cell1_q;
    logic [2:0]        cell2_q;
    logic [2:0]        cell0_next;
    logic [2:0]        cell1_next;
    logic [2:0]        cell2_next;

    // output queue, entry 0 is the head
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic [CELL_W-1:0] q0_data_reg;
    logic              q0_last_reg;
    logic [CELL_W-1:0] q1_data_reg;
    logic              q1_last_reg;
    logic              push;
    logic              pop;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= lgs_pkg::FRAME_WIDTH_RESET;
            fh_reg <= lgs_pkg::FRAME_HEIGHT_RESET;
            dm_reg <= lgs_pkg::DEAD_MARK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                lgs_pkg::REG_FRAME_WIDTH:  fw_reg <= cfg_data;
                lgs_pkg::REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                lgs_pkg::REG_DEAD_MARK:    dm_reg <= cfg_data[CELL_W-1:0];
                default:                   ;
            endcase
        end
    end

    // zero counts as one, larger values saturate at the maximum
    always_comb
    begin
        if (fw_reg == '0)
        begin
            wc = WC_W'(1);
        end
        else if (32'(fw_reg) > MAX_WIDTH)
        begin
            wc = WC_W'(MAX_WIDTH);
        end
        else
        begin
            wc = WC_W'(fw_reg);
        end

        if (fh_reg == '0)
        begin
            hc = HC_W'(1);
        end
        else if (32'(fh_reg) > MAX_HEIGHT)
        begin
            hc = HC_W'(MAX_HEIGHT);
        end
        else
        begin
            hc = HC_W'(fh_reg);
        end

        wh_prod = PR_W'(wc) * PR_W'(hc);
    end

    // registered product, settles long before the position recompute ends
    always_ff @(posedge clk)
    begin
        wh_reg <= wh_prod[WH_W-1:0];
    end

    // ------------------------------------------------------------------
    // control sequence: clearing pass, position recompute, streaming
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lgs_pkg::ST_CLEAR:
            begin
                if (!lb_clearing)
                begin
                    state_next = lgs_pkg::ST_LOAD;
                end
            end
            lgs_pkg::ST_START:  state_next = lgs_pkg::ST_DIVIDE;
            lgs_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = lgs_pkg::ST_LOAD;
                end
            end
            lgs_pkg::ST_LOAD:   state_next = lgs_pkg::ST_RUN;
            lgs_pkg::ST_RUN:    state_next = lgs_pkg::ST_RUN;
            default:            state_next = lgs_pkg::ST_CLEAR;
        endcase
        // a new width may move the column of the current position
        if (cfg_we && (state_reg != lgs_pkg::ST_CLEAR))
        begin
            state_next = lgs_pkg::ST_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lgs_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign div_start = (state_reg == lgs_pkg::ST_START);
    assign s_tready  = (state_reg == lgs_pkg::ST_RUN) && (cnt_reg != 2'd2);
    assign accept    = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // cell column: new bottom cell, previous two rows from the line buffer
    // ------------------------------------------------------------------
    always_comb
    begin
        cell_bot   = (s_tuser == lgs_pkg::CMD_CELL) && (s_tdata == lgs_pkg::ALIVE_BYTE)
                     && (r_reg < P_W'(hc));
        cell_mid   = (r_reg != '0) && lb_rd_data[0];
        cell_top   = (r_reg >= P_W'(2)) && lb_rd_data[1];
        col        = {cell_bot, cell_mid, cell_top};
        col_first  = (c_reg == '0);
        col_last   = (WC_W'(c_reg) == (wc - WC_W'(1)));
        has_result = p_reg >= (P_W'(wc) + P_W'(1));
        frame_last = (WH_W'(out_pos_reg) + WH_W'(1)) >= wh_reg;
    end

    // window chain, newest column in cell 0
    lgs_window_cell u_cell0
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (accept),
        .flush  (1'b0),
        .d      (col),
        .q      (cell0_q),
        .q_next (cell0_next)
    );

    lgs_window_cell u_cell1
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (accept),
        .flush  (col_first),
        .d      (cell0_q),
        .q      (cell1_q),
        .q_next (cell1_next)
    );

    lgs_window_cell u_cell2
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (accept),
        .flush  (col_first),
        .d      (cell1_q),
        .q      (cell2_q),
        .q_next (cell2_next)
    );

    assign win_next = {cell2_next, cell1_next, cell0_next};

    // first column of a row takes the result saved at the end of the row before
    always_comb
    begin
        alive     = col_first ? edge_reg : lgs_pkg::life_rule(win_next);
        res_data  = alive ? lgs_pkg::ALIVE_BYTE : dm_reg;
        edge_next = edge_reg;
        if (accept && col_last)
        begin
            edge_next = lgs_pkg::life_rule({win_next[5:0], 3'b000});
        end
    end

    // ------------------------------------------------------------------
    // position counters
    // ------------------------------------------------------------------
    always_comb
    begin
        p_next       = p_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        out_pos_next = out_pos_reg;
        if (accept)
        begin
            if (has_result && frame_last)
            begin
                p_next       = '0;
                r_next       = '0;
                c_next       = '0;
                out_pos_next = '0;
            end
            else
            begin
                p_next = p_reg + P_W'(1);
                if (has_result)
                begin
                    out_pos_next = out_pos_reg + O_W'(1);
                end
                if (col_last)
                begin
                    c_next = '0;
                    r_next = r_reg + P_W'(1);
                end
                else
                begin
                    c_next = c_reg + C_W'(1);
                end
            end
        end
        else if ((state_reg == lgs_pkg::ST_DIVIDE) && div_done)
        begin
            r_next = div_quo;
            c_next = div_rem[C_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg       <= '0;
            r_reg       <= '0;
            c_reg       <= '0;
            out_pos_reg <= '0;
            edge_reg    <= 1'b0;
        end
        else
        begin
            p_reg       <= p_next;
            r_reg       <= r_next;
            c_reg       <= c_next;
            out_pos_reg <= out_pos_next;
            edge_reg    <= edge_next;
        end
    end

    // ------------------------------------------------------------------
    // line buffer: write this column, fetch the next one
    // ------------------------------------------------------------------
    assign lb_rd_en = accept || (state_reg == lgs_pkg::ST_LOAD);

    lgs_line_buffer
    #(
        .DEPTH (MAX_WIDTH)
    )
    u_line_buffer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_addr  (c_reg),
        .wr_data  ({cell_mid, cell_bot}),
        .rd_en    (lb_rd_en),
        .rd_addr  (c_next),
        .rd_data  (lb_rd_data),
        .clearing (lb_clearing)
    );

    // ------------------------------------------------------------------
    // row and column of the current position after a width change
    // ------------------------------------------------------------------
    lgs_pos_divider
    #(
        .NUM_W (P_W),
        .DEN_W (WC_W)
    )
    u_pos_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (p_reg),
        .den   (wc),
        .quo   (div_quo),
        .rem   (div_rem),
        .done  (div_done)
    );

    // ------------------------------------------------------------------
    // output queue, two entries
    // ------------------------------------------------------------------
    assign push = accept && has_result;
    assign pop  = (cnt_reg != 2'd0) && m_tready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (push && (cnt_reg == 2'd1))
            begin
                q0_data_reg <= res_data;
                q0_last_reg <= frame_last;
            end
            else
            begin
                q0_data_reg <= q1_data_reg;
                q0_last_reg <= q1_last_reg;
            end
            if (push && (cnt_reg == 2'd2))
            begin
                q1_data_reg <= res_data;
                q1_last_reg <= frame_last;
            end
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                q0_data_reg <= res_data;
                q0_last_reg <= frame_last;
            end
            else
            begin
                q1_data_reg <= res_data;
                q1_last_reg <= frame_last;
            end
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = q0_data_reg;
    assign m_tlast  = q0_last_reg;

endmodule

`default_nettype wire

// ----- hdl/lgs_checker.sv -----
// port-level checks for the life generation stencil, bound to the top level
`default_nettype none

module lgs_checker
(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [lgs_pkg::CELL_W-1:0]     s_tdata,
    input wire logic                           s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [lgs_pkg::CELL_W-1:0]     m_tdata,
    input wire logic                           m_tlast,
    input wire logic                           cfg_we,
    input wire logic [lgs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input wire logic [lgs_pkg::CFG_DATA_W-1:0] cfg_data
);

    // shadow of the dead marker as written on the port
    logic [lgs_pkg::CELL_W-1:0] dm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dm_reg <= lgs_pkg::DEAD_MARK_RESET;
        end
        else if (cfg_we && (cfg_addr == lgs_pkg::REG_DEAD_MARK))
        begin
            dm_reg <= cfg_data[lgs_pkg::CELL_W-1:0];
        end
    end

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transaction withdrawn while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // every result is either the live byte or the current dead marker
    a_out_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == lgs_pkg::ALIVE_BYTE) || (m_tdata == dm_reg))
        else $error("output byte is neither live nor dead marker");

    // the line buffer sweep keeps input closed right after reset
    a_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_tready)
        else $error("input open before the line buffer sweep");

    // a configuration write closes input while the position is recomputed
    a_cfg_closed: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_tready)
        else $error("input open right after a configuration write");

    // input data is otherwise unused here
    logic unused_in;
    assign unused_in = s_tvalid ^ s_tuser ^ (^s_tdata);

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
);

`default_nettype wire

// ----- test/life_generation_stencil_checker.sv -----
// checker for the life generation stencil: next-generation predictor and result comparison
module life_generation_stencil_checker
#(
    parameter int MAX_DIM = 256
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [lgs_pkg::CELL_W-1:0]     s_tdata,
    input  wire logic                           s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [lgs_pkg::CELL_W-1:0]     m_tdata,
    input  wire logic                           m_tlast,
    input  wire logic                           cfg_we,
    input  wire logic [lgs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [lgs_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                  awaiting,
    output int                                  fault_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [lgs_pkg::CELL_W-1:0] next_value;
        logic                       frame_end;
    } next_cell_t;

    next_cell_t next_gen_q[$];
    next_cell_t want;
    int         faults;

    // own copy of the registers
    logic [lgs_pkg::DIM_W-1:0]  width_reg;
    logic [lgs_pkg::DIM_W-1:0]  height_reg;
    logic [lgs_pkg::CELL_W-1:0] dead_byte;

    // line history, 3x3 window and frame positions
    logic        older_row [MAX_DIM];
    logic        newer_row [MAX_DIM];
    logic [8:0]  window;
    int unsigned cells_in;
    int unsigned cells_out;
    logic        row_end_next;

    function automatic int unsigned frame_dim(input logic [lgs_pkg::DIM_W-1:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (v > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return v;
    endfunction

    // b3/s23 on the window, centre at bit 4
    function automatic logic survives(input logic [8:0] win);
        int n;
        n = $countones(win) - int'(win[4]);
        if (win[4])
        begin
            return (n == 2) || (n == 3);
        end
        return n == 3;
    endfunction

    task automatic advance_generation(input logic cmd,
                                      input logic [lgs_pkg::CELL_W-1:0] value);
        int unsigned w;
        int unsigned h;
        int unsigned row;
        int unsigned col;
        logic        new_bit;
        logic        mid_bit;
        logic        old_bit;
        logic        alive;
        logic        last;
        w = frame_dim(width_reg);
        h = frame_dim(height_reg);
        row = cells_in / w;
        col = cells_in % w;
        // padding rows and flushes are dead whatever the byte
        new_bit = (cmd == lgs_pkg::CMD_CELL) && (value == lgs_pkg::ALIVE_BYTE) && (row < h);
        mid_bit = (row >= 1) ? newer_row[col] : 1'b0;
        old_bit = (row >= 2) ? older_row[col] : 1'b0;
        older_row[col] = mid_bit;
        newer_row[col] = new_bit;
        if (col == 0)
        begin
            window = '0;
        end
        window = {window[5:0], new_bit, mid_bit, old_bit};
        // the last cell of a row is settled one column late, with a dead right edge
        alive = (col == 0) ? row_end_next : survives(window);
        if (col == w - 1)
        begin
            row_end_next = survives({window[5:0], 3'b000});
        end
        if (cells_in >= w + 1)
        begin
            last = cells_out >= w * h - 1;
            next_gen_q.push_back('{alive ? lgs_pkg::ALIVE_BYTE : dead_byte, last});
            if (last)
            begin
                cells_in = 0;
                cells_out = 0;
            end
            else
            begin
                cells_in++;
                cells_out++;
            end
        end
        else
        begin
            cells_in++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_gen_q.delete();
            faults = 0;
            width_reg = lgs_pkg::FRAME_WIDTH_RESET;
            height_reg = lgs_pkg::FRAME_HEIGHT_RESET;
            dead_byte = lgs_pkg::DEAD_MARK_RESET;
            for (int i = 0; i < MAX_DIM; i++)
            begin
                older_row[i] = 1'b0;
                newer_row[i] = 1'b0;
            end
            window = '0;
            cells_in = 0;
            cells_out = 0;
            row_end_next = 1'b0;
            awaiting <= 0;
            fault_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    lgs_pkg::REG_FRAME_WIDTH:  width_reg = cfg_data;
                    lgs_pkg::REG_FRAME_HEIGHT: height_reg = cfg_data;
                    lgs_pkg::REG_DEAD_MARK:    dead_byte = cfg_data[lgs_pkg::CELL_W-1:0];
                    default:                   ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (next_gen_q.size() == 0)
                begin
                    $error("unexpected result: next_value %0d frame_end %0b", m_tdata, m_tlast);
                    faults++;
                end
                else
                begin
                    want = next_gen_q.pop_front();
                    if (m_tdata !== want.next_value)
                    begin
                        $error("next_value: expected %0d, got %0d", want.next_value, m_tdata);
                        faults++;
                    end
                    if (m_tlast !== want.frame_end)
                    begin
                        $error("frame_end: expected %0b, got %0b", want.frame_end, m_tlast);
                        faults++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                advance_generation(s_tuser, s_tdata);
            end
            awaiting <= next_gen_q.size();
            fault_count <= faults;
        end
    end

endmodule

// ----- test/life_generation_stencil_tb.sv -----
// testbench top for the life generation stencil: stimulus, back-pressure and verdict
module life_generation_stencil_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  MAX_DIM     = 256;
    localparam int  ITEM_TARGET = 1750;
    localparam int  CYCLE_LIMIT = 500000;
    // a flush transaction pads past the frame end
    localparam logic CMD_FLUSH  = 1'b1;
    // results before the receiver goes quiet for a long stretch
    localparam int  HOLD_AFTER  = 60;
    localparam int  HOLD_CYCLES = 300;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [lgs_pkg::CELL_W-1:0]     s_tdata;   // [7:0] cell_value
    logic                           s_tuser;   // [0] command
    logic                           m_tvalid;
    logic                           m_tready;
    logic [lgs_pkg::CELL_W-1:0]     m_tdata;   // [7:0] next_value
    logic                           m_tlast;
    logic                           cfg_we;
    logic [lgs_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [lgs_pkg::CFG_DATA_W-1:0] cfg_data;

    int awaiting;
    int fault_count;
    int items_sent;
    int cycle_count;
    bit send_burst;
    bit recv_burst;

    life_generation_stencil #(
        .MAX_WIDTH  (MAX_DIM),
        .MAX_HEIGHT (MAX_DIM)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    life_generation_stencil_checker #(
        .MAX_DIM (MAX_DIM)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .awaiting    (awaiting),
        .fault_count (fault_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // hard stop in case a result never arrives or the input stalls for good
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL life_generation_stencil");
        $finish;
    end

    // same saturation the block applies to its size registers
    function automatic int frame_dim(input logic [lgs_pkg::DIM_W-1:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (v > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return v;
    endfunction

    task automatic write_reg(input lgs_pkg::reg_index_t idx,
                             input logic [lgs_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [lgs_pkg::DIM_W-1:0] w,
                             input logic [lgs_pkg::DIM_W-1:0] h,
                             input logic [lgs_pkg::CELL_W-1:0] dead);
        write_reg(lgs_pkg::REG_FRAME_WIDTH, w);
        write_reg(lgs_pkg::REG_FRAME_HEIGHT, h);
        write_reg(lgs_pkg::REG_DEAD_MARK, 9'(dead));
    endtask

    // one input transaction; an optional random gap comes first, and valid stays
    // high across back-to-back transactions
    task automatic send_item(input logic cmd, input logic [lgs_pkg::CELL_W-1:0] value);
        int gap;
        if (items_sent % 32 == 0)
        begin
            send_burst = ($urandom_range(0, 3) == 0);
        end
        gap = send_burst ? 0 : $urandom_range(0, 9);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= value;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        items_sent++;
    endtask

    // a full frame is w*h cells and w+1 flushes, so the last transaction always
    // brings out the frame_end result; a few cells turn into early flushes and a
    // few flushes into cells in the padding rows, both of which count as dead
    task automatic send_frame(input int w, input int h);
        int density;
        int noise;
        logic cmd;
        logic [lgs_pkg::CELL_W-1:0] value;
        density = $urandom_range(15, 60);
        noise = $urandom_range(0, 8);
        for (int i = 0; i < w * h + w + 1; i++)
        begin
            if (i < w * h)
            begin
                cmd = ($urandom_range(0, 99) < noise) ? CMD_FLUSH : lgs_pkg::CMD_CELL;
            end
            else
            begin
                cmd = ($urandom_range(0, 99) < noise) ? lgs_pkg::CMD_CELL : CMD_FLUSH;
            end
            if ($urandom_range(0, 99) < density)
            begin
                value = lgs_pkg::ALIVE_BYTE;
            end
            else
            begin
                value = lgs_pkg::CELL_W'($urandom_range(0, 255));
            end
            send_item(cmd, value);
        end
    endtask

    // drop valid, let every expected result drain, then idle before the registers may
    // be touched again
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (awaiting != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic run_phase(input logic [lgs_pkg::DIM_W-1:0] w,
                             input logic [lgs_pkg::DIM_W-1:0] h,
                             input logic [lgs_pkg::CELL_W-1:0] dead, input int frames);
        configure(w, h, dead);
        repeat (frames) send_frame(frame_dim(w), frame_dim(h));
        settle();
    endtask

    // receiver: random stalls per result, bursts of full speed, and one long
    // hold-off early in the run so the output queue fills and the input stalls
    initial
    begin
        int gap;
        int results_seen;
        int hold;
        m_tready = 1'b0;
        recv_burst = 1'b0;
        results_seen = 0;
        @(posedge rst_n);
        forever
        begin
            if (results_seen % 32 == 0)
            begin
                recv_burst = ($urandom_range(0, 3) == 0);
            end
            gap = recv_burst ? 0 : $urandom_range(0, 9);
            if (results_seen == HOLD_AFTER)
            begin
                hold = 0;
                while (hold < HOLD_CYCLES)
                begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                    hold++;
                end
            end
            repeat (gap)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_tvalid);
            results_seen++;
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [lgs_pkg::DIM_W-1:0]  w_reg;
        logic [lgs_pkg::DIM_W-1:0]  h_reg;
        logic [lgs_pkg::CELL_W-1:0] dead;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = lgs_pkg::CMD_CELL;
        cfg_we = 1'b0;
        cfg_addr = lgs_pkg::REG_FRAME_WIDTH;
        cfg_data = '0;
        items_sent = 0;
        send_burst = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // line buffer sweep after reset: ready comes up when it is done
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);

        // 3x3, a vertical line plus one live cell; not-quite-alive bytes, an early flush
        // holding 255 and a live byte in the padding row must all count as dead
        configure(9'd3, 9'd3, 8'hA5);
        send_item(lgs_pkg::CMD_CELL, 8'h00);
        send_item(lgs_pkg::CMD_CELL, 8'hFF);
        send_item(lgs_pkg::CMD_CELL, 8'hFE);
        send_item(lgs_pkg::CMD_CELL, 8'h7F);
        send_item(lgs_pkg::CMD_CELL, 8'hFF);
        send_item(CMD_FLUSH, 8'hFF);
        send_item(lgs_pkg::CMD_CELL, 8'h80);
        send_item(lgs_pkg::CMD_CELL, 8'hFF);
        send_item(lgs_pkg::CMD_CELL, 8'hFF);
        send_item(CMD_FLUSH, 8'h00);
        send_item(lgs_pkg::CMD_CELL, 8'hFF);
        send_item(CMD_FLUSH, 8'h55);
        send_item(CMD_FLUSH, 8'hAA);
        settle();

        // zero width counts as one: a single live cell with no neighbours dies
        configure(9'd0, 9'd1, 8'hFF);
        send_item(lgs_pkg::CMD_CELL, 8'hFF);
        send_item(CMD_FLUSH, 8'h00);
        send_item(CMD_FLUSH, 8'h00);
        settle();

        // 2x2 block, every cell has three neighbours and survives
        configure(9'd2, 9'd2, 8'h00);
        send_item(lgs_pkg::CMD_CELL, 8'hFF);
        send_item(lgs_pkg::CMD_CELL, 8'hFF);
        send_item(lgs_pkg::CMD_CELL, 8'hFF);
        send_item(lgs_pkg::CMD_CELL, 8'hFF);
        send_item(CMD_FLUSH, 8'h00);
        send_item(CMD_FLUSH, 8'h00);
        send_item(CMD_FLUSH, 8'h00);
        settle();

        // a mid-sized frame, long enough to ride through the receiver hold-off
        run_phase(9'd16, 9'd16, 8'h00, 1);
        // oversize width saturates to the full line, zero height counts as one row
        run_phase(9'd511, 9'd0, lgs_pkg::CELL_W'($urandom_range(0, 255)), 1);
        // one column, oversize height saturates to the full frame
        run_phase(9'd1, 9'd511, 8'hFF, 1);

        // random small frames make up the rest
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                w_reg = lgs_pkg::DIM_W'($urandom_range(13, 40));
            end
            else
            begin
                w_reg = lgs_pkg::DIM_W'($urandom_range(0, 12));
            end
            h_reg = lgs_pkg::DIM_W'($urandom_range(0, 12));
            case ($urandom_range(0, 3))
                0:       dead = 8'h00;
                1:       dead = 8'hFF;
                default: dead = lgs_pkg::CELL_W'($urandom_range(0, 255));
            endcase
            run_phase(w_reg, h_reg, dead, $urandom_range(1, 3));
        end

        repeat (16) @(negedge clk);
        if (fault_count == 0 && awaiting == 0)
        begin
            $display("PASS life_generation_stencil");
        end
        else
        begin
            $display("FAIL life_generation_stencil");
        end
        $finish;
    end

endmodule
